>>> hw/rtl/fsc_pkg.sv
package fsc_pkg;

    // Fixed-point fraction bits of entries, centre coordinates and radius
    localparam int FRAC_BITS  = 16;

    localparam int NUM_ROWS   = 4;
    localparam int NUM_AXES   = 3;
    localparam int NUM_PLANES = 6;
    localparam int NUM_ENTRY  = 16;
    localparam int IDX_W      = 4;

    localparam int VAL_W      = 32;            // entry and centre width
    localparam int RAD_W      = 31;            // radius width
    localparam int COMP_W     = VAL_W + 1;     // plane component, exact sum
    localparam int CMAG_W     = COMP_W;        // |component| <= 2^32
    localparam int PROD_W     = 2 * VAL_W;     // entry * centre
    localparam int SQ_W       = 2 * CMAG_W;    // component squared
    localparam int DOT_W      = PROD_W + 2;    // row dot product plus offset
    localparam int D_W        = DOT_W + 1;     // plane distance, signed
    localparam int MAG_W      = DOT_W;         // |distance|
    localparam int N2_W       = SQ_W;          // |n|^2 <= 3 * 2^64
    localparam int RR_W       = 2 * RAD_W;     // r^2
    localparam int HALF_W     = MAG_W / 2;     // limb of |d| and |n|^2
    localparam int RR_HALF_W  = RR_W / 2;      // limb of r^2
    localparam int SQP_W      = 2 * HALF_W;    // limb product of |d|^2
    localparam int RNP_W      = RR_HALF_W + HALF_W; // limb product of r^2|n|^2
    localparam int DD_W       = 2 * MAG_W;     // |d|^2
    localparam int RN_W       = RR_W + N2_W;   // r^2 |n|^2

    // Item function codes
    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TEST = 1'b1
    } fsc_func_t;

    // Register enables of the per-plane stages
    typedef struct packed {
        logic st3;
        logic st4;
        logic st5;
    } fsc_stage_en_t;

endpackage

>>> hw/rtl/fsc_plane.sv
module fsc_plane import fsc_pkg::*; (
    input  logic                     aclk,
    input  fsc_stage_en_t            en,
    input  logic                     plane_add,
    input  logic signed [DOT_W-1:0]  dot3,
    input  logic signed [DOT_W-1:0]  dotk,
    input  logic        [N2_W-1:0]   n2,
    input  logic        [RR_W-1:0]   rr,
    input  logic                     nz,
    output logic                     cull
);

    // stage 3: distance, its sign and magnitude
    logic signed [D_W-1:0]   d_pos;
    logic signed [D_W-1:0]   d_neg;
    logic        [MAG_W-1:0] mag_next;
    logic                    flag3_next;
    logic        [MAG_W-1:0] mag_reg;
    logic        [N2_W-1:0]  n2_reg;
    logic        [RR_W-1:0]  rr_reg;
    logic                    flag3_reg;

    // stage 4: limb products
    logic [SQP_W-1:0] hh_next, hl_next, ll_next;
    logic [RNP_W-1:0] phh_next, phl_next, plh_next, pll_next;
    logic [SQP_W-1:0] hh_reg, hl_reg, ll_reg;
    logic [RNP_W-1:0] phh_reg, phl_reg, plh_reg, pll_reg;
    logic             flag4_reg;

    // stage 5: full squares
    logic [DD_W-1:0] dd_next;
    logic [RN_W-1:0] rn_next;
    logic [DD_W-1:0] dd_reg;
    logic [RN_W-1:0] rn_reg;
    logic            flag5_reg;

    always_comb begin
        if (plane_add) begin
            d_pos = D_W'(dot3) + D_W'(dotk);
            d_neg = ~D_W'(dot3) - D_W'(dotk) + D_W'(1);
        end else begin
            d_pos = D_W'(dot3) - D_W'(dotk);
            d_neg = D_W'(dotk) - D_W'(dot3);
        end
        mag_next   = d_pos[D_W-1] ? MAG_W'(d_neg) : MAG_W'(d_pos);
        // culling needs a nonzero normal and the centre not strictly inside
        flag3_next = nz && (d_pos[D_W-1] || (d_pos == '0));
    end

    always_ff @(posedge aclk) begin
        if (en.st3) begin
            mag_reg   <= mag_next;
            n2_reg    <= n2;
            rr_reg    <= rr;
            flag3_reg <= flag3_next;
        end
    end

    always_comb begin
        hh_next  = SQP_W'(mag_reg[MAG_W-1:HALF_W]) * SQP_W'(mag_reg[MAG_W-1:HALF_W]);
        hl_next  = SQP_W'(mag_reg[MAG_W-1:HALF_W]) * SQP_W'(mag_reg[HALF_W-1:0]);
        ll_next  = SQP_W'(mag_reg[HALF_W-1:0])     * SQP_W'(mag_reg[HALF_W-1:0]);
        phh_next = RNP_W'(rr_reg[RR_W-1:RR_HALF_W]) * RNP_W'(n2_reg[N2_W-1:HALF_W]);
        phl_next = RNP_W'(rr_reg[RR_W-1:RR_HALF_W]) * RNP_W'(n2_reg[HALF_W-1:0]);
        plh_next = RNP_W'(rr_reg[RR_HALF_W-1:0])    * RNP_W'(n2_reg[N2_W-1:HALF_W]);
        pll_next = RNP_W'(rr_reg[RR_HALF_W-1:0])    * RNP_W'(n2_reg[HALF_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (en.st4) begin
            hh_reg    <= hh_next;
            hl_reg    <= hl_next;
            ll_reg    <= ll_next;
            phh_reg   <= phh_next;
            phl_reg   <= phl_next;
            plh_reg   <= plh_next;
            pll_reg   <= pll_next;
            flag4_reg <= flag3_reg;
        end
    end

    // high and low squares do not overlap, cross term counted twice
    always_comb begin
        dd_next = {hh_reg, ll_reg} + (DD_W'(hl_reg) << (HALF_W + 1));
        rn_next = {phh_reg, pll_reg} + (RN_W'(phl_reg) << RR_HALF_W)
                + (RN_W'(plh_reg) << HALF_W);
    end

    always_ff @(posedge aclk) begin
        if (en.st5) begin
            dd_reg    <= dd_next;
            rn_reg    <= rn_next;
            flag5_reg <= flag4_reg;
        end
    end

    assign cull = flag5_reg && (dd_reg >= DD_W'(rn_reg));

endmodule

>>> hw/rtl/frustum_sphere_cull.sv
// Channel  | Ports                                            | Beat
// ---------+--------------------------------------------------+---------------------------
// input    | s_valid s_ready s_func s_entry_index             | load one entry or test one
//          | s_entry_value s_center_x/y/z s_sphere_radius     | sphere
// result   | m_valid m_ready m_visible                        | one per test, none per load
//
// One item per cycle while s_ready is high. A test passes through six register stages
// on its way to the result beat, in order: products, sums, distances, limb products,
// squares, compare.
// A load writes the matrix at acceptance and is seen by the very next test.
// Reset (aresetn low at a clock edge) clears the matrix and all stage valids.
// Each stage advances when it is empty or the one after it moves, so bubbles close up
// and a held result stalls only what is behind it.
module frustum_sphere_cull import fsc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_func,
    input  logic        [IDX_W-1:0]  s_entry_index,
    input  logic signed [VAL_W-1:0]  s_entry_value,
    input  logic signed [VAL_W-1:0]  s_center_x,
    input  logic signed [VAL_W-1:0]  s_center_y,
    input  logic signed [VAL_W-1:0]  s_center_z,
    input  logic        [RAD_W-1:0]  s_sphere_radius,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_visible
);

    localparam int NUM_STAGES = 6;

    logic signed [VAL_W-1:0] mat_reg [NUM_ENTRY];

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] rdy;

    logic signed [VAL_W-1:0]  ctr [NUM_AXES];
    logic signed [COMP_W-1:0] comp [NUM_PLANES][NUM_AXES];
    logic        [CMAG_W-1:0] cmag [NUM_PLANES][NUM_AXES];

    // stage 1
    logic signed [PROD_W-1:0] prod_next [NUM_ROWS][NUM_AXES];
    logic        [SQ_W-1:0]   sq_next   [NUM_PLANES][NUM_AXES];
    logic        [NUM_PLANES-1:0] nz_next;
    logic        [RR_W-1:0]   rr_next;
    logic signed [PROD_W-1:0] prod_reg  [NUM_ROWS][NUM_AXES];
    logic signed [VAL_W-1:0]  wv_reg    [NUM_ROWS];
    logic        [SQ_W-1:0]   sq_reg    [NUM_PLANES][NUM_AXES];
    logic        [NUM_PLANES-1:0] nz_reg;
    logic        [RR_W-1:0]   rr_reg;

    // stage 2
    logic signed [DOT_W-1:0]  dot_next [NUM_ROWS];
    logic        [N2_W-1:0]   n2_next  [NUM_PLANES];
    logic signed [DOT_W-1:0]  dot_reg  [NUM_ROWS];
    logic        [N2_W-1:0]   n2_reg   [NUM_PLANES];
    logic        [NUM_PLANES-1:0] nz2_reg;
    logic        [RR_W-1:0]   rr2_reg;

    fsc_stage_en_t            plane_en;
    logic [NUM_PLANES-1:0]    cull;
    logic                     visible_reg;

    // handshake and stage valids
    always_comb begin
        rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        valid_next = valid_reg;
        if (rdy[0]) begin
            valid_next[0] = s_valid && (s_func == FUNC_TEST);
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (rdy[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    // matrix store, written on a load beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ENTRY; i++) begin
                mat_reg[i] <= '0;
            end
        end else if (s_valid && s_ready && (s_func == FUNC_LOAD)) begin
            mat_reg[s_entry_index] <= s_entry_value;
        end
    end

    assign ctr[0] = s_center_x;
    assign ctr[1] = s_center_y;
    assign ctr[2] = s_center_z;

    // plane 2k is row 3 minus row k, plane 2k+1 is row 3 plus row k
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                comp[2*k][i]   = COMP_W'(mat_reg[i*NUM_ROWS+3])
                               - COMP_W'(mat_reg[i*NUM_ROWS+k]);
                comp[2*k+1][i] = COMP_W'(mat_reg[i*NUM_ROWS+3])
                               + COMP_W'(mat_reg[i*NUM_ROWS+k]);
            end
        end
    end

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                cmag[p][i]    = comp[p][i][COMP_W-1] ? CMAG_W'(-comp[p][i])
                                                     : CMAG_W'(comp[p][i]);
                sq_next[p][i] = SQ_W'(cmag[p][i]) * SQ_W'(cmag[p][i]);
            end
            nz_next[p] = (comp[p][0] != '0) || (comp[p][1] != '0) || (comp[p][2] != '0);
        end
        // row j of the matrix dotted with the centre, per axis
        for (int j = 0; j < NUM_ROWS; j++) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                prod_next[j][i] = PROD_W'(mat_reg[i*NUM_ROWS+j]) * PROD_W'(ctr[i]);
            end
        end
        rr_next = RR_W'(s_sphere_radius) * RR_W'(s_sphere_radius);
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            prod_reg <= prod_next;
            sq_reg   <= sq_next;
            nz_reg   <= nz_next;
            rr_reg   <= rr_next;
            for (int j = 0; j < NUM_ROWS; j++) begin
                wv_reg[j] <= mat_reg[NUM_AXES*NUM_ROWS+j];
            end
        end
    end

    // offset carries FRAC_BITS more fraction bits to line up with the products
    always_comb begin
        for (int j = 0; j < NUM_ROWS; j++) begin
            dot_next[j] = DOT_W'(prod_reg[j][0]) + DOT_W'(prod_reg[j][1])
                        + DOT_W'(prod_reg[j][2]) + (DOT_W'(wv_reg[j]) <<< FRAC_BITS);
        end
        for (int p = 0; p < NUM_PLANES; p++) begin
            n2_next[p] = N2_W'(sq_reg[p][0]) + N2_W'(sq_reg[p][1]) + N2_W'(sq_reg[p][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            dot_reg <= dot_next;
            n2_reg  <= n2_next;
            nz2_reg <= nz_reg;
            rr2_reg <= rr_reg;
        end
    end

    assign plane_en.st3 = rdy[2];
    assign plane_en.st4 = rdy[3];
    assign plane_en.st5 = rdy[4];

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
        for (genvar s = 0; s < 2; s++) begin : g_side
            fsc_plane u_plane (
                .aclk      (aclk),
                .en        (plane_en),
                .plane_add ((s == 1) ? 1'b1 : 1'b0),
                .dot3      (dot_reg[3]),
                .dotk      (dot_reg[k]),
                .n2        (n2_reg[2*k+s]),
                .rr        (rr2_reg),
                .nz        (nz2_reg[2*k+s]),
                .cull      (cull[2*k+s])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NUM_STAGES-1]) begin
            visible_reg <= !(|cull);
        end
    end

    assign m_visible = visible_reg;

endmodule

>>> test/frustum_sphere_cull_tb.sv
`timescale 1ns / 100ps

module frustum_sphere_cull_tb;
    import fsc_pkg::*;

    localparam int ONE            = 1 << FRAC_BITS;
    localparam int TARGET_BEATS   = 1500;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 20;

    // Tracks the matrix as loaded and the visibility expected for each sphere test.
    class cull_scoreboard;
        logic signed [VAL_W-1:0] matrix [NUM_ENTRY];
        bit visible_q [$];
        int mismatches;
        int loads;
        int tests;
        int checked;
        int culled_seen;

        function new();
            foreach (matrix[i]) matrix[i] = '0;
        endfunction

        // Exact test d <= -r|n|, done as d <= 0 and d^2 >= r^2 |n|^2.
        function bit plane_culls(logic signed [127:0] a, b, c, w, x, y, z,
                                 logic [127:0] r);
            logic signed [127:0] d;
            logic signed [127:0] n2;
            logic signed [127:0] dmag;
            logic [255:0] dd;
            logic [255:0] rn;
            if (a == 0 && b == 0 && c == 0) return 1'b0;
            d = a * x + b * y + c * z + (w <<< FRAC_BITS);
            if (d > 0) return 1'b0;
            dmag = -d;
            n2 = a * a + b * b + c * c;
            dd = {128'b0, dmag} * {128'b0, dmag};
            rn = {128'b0, r} * {128'b0, r} * {128'b0, n2};
            return dd >= rn;
        endfunction

        function bit sphere_culled(logic signed [VAL_W-1:0] cx, cy, cz,
                                   logic [RAD_W-1:0] rad);
            logic signed [127:0] p [NUM_ROWS];
            logic signed [127:0] col3;
            logic signed [127:0] e;
            for (int k = 0; k < NUM_AXES; k++) begin
                for (int s = 0; s < 2; s++) begin
                    for (int i = 0; i < NUM_ROWS; i++) begin
                        col3 = 128'(matrix[i * 4 + 3]);
                        e = 128'(matrix[i * 4 + k]);
                        p[i] = (s == 0) ? col3 - e : col3 + e;
                    end
                    if (plane_culls(p[0], p[1], p[2], p[3], 128'(cx), 128'(cy), 128'(cz),
                                    128'(rad)))
                        return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_beat(fsc_func_t func, logic [IDX_W-1:0] idx,
                                logic signed [VAL_W-1:0] val, cx, cy, cz,
                                logic [RAD_W-1:0] rad);
            if (func == FUNC_LOAD) begin
                matrix[idx] = val;
                loads++;
            end else begin
                visible_q.push_back(!sphere_culled(cx, cy, cz, rad));
                tests++;
            end
        endfunction

        function void check_visible(logic vis);
            bit want;
            if (visible_q.size() == 0) begin
                $error("visible: no test outstanding, actual %0b", vis);
                mismatches++;
                return;
            end
            want = visible_q.pop_front();
            checked++;
            if (!want) culled_seen++;
            if (vis !== want) begin
                $error("visible: expected %0b, actual %0b", want, vis);
                mismatches++;
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_func = 1'b0;
    logic        [IDX_W-1:0]  s_entry_index = '0;
    logic signed [VAL_W-1:0]  s_entry_value = '0;
    logic signed [VAL_W-1:0]  s_center_x = '0;
    logic signed [VAL_W-1:0]  s_center_y = '0;
    logic signed [VAL_W-1:0]  s_center_z = '0;
    logic        [RAD_W-1:0]  s_sphere_radius = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_visible;

    cull_scoreboard sb = new;
    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int beats_sent = 0;

    frustum_sphere_cull u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_entry_index   (s_entry_index),
        .s_entry_value   (s_entry_value),
        .s_center_x      (s_center_x),
        .s_center_y      (s_center_y),
        .s_center_z      (s_center_z),
        .s_sphere_radius (s_sphere_radius),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_visible       (m_visible)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #1000000;
        $display("[frustum_sphere_cull] ERROR");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_ready = 1'b0;
            end else begin
                m_ready = quiet || ($urandom_range(99) >= 20);
            end
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_visible(m_visible);
        end
    end

    function automatic int spread(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic send_beat(fsc_func_t func, logic [IDX_W-1:0] idx,
                             logic signed [VAL_W-1:0] val, cx, cy, cz,
                             logic [RAD_W-1:0] rad);
        while (!quiet && $urandom_range(99) < 20) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid         = 1'b1;
        s_func          = func;
        s_entry_index   = idx;
        s_entry_value   = val;
        s_center_x      = cx;
        s_center_y      = cy;
        s_center_z      = cz;
        s_sphere_radius = rad;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(func, idx, val, cx, cy, cz, rad);
        beats_sent++;
    endtask

    // Unused fields carry noise so the block is seen to ignore them.
    task automatic load_entry(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val);
        send_beat(FUNC_LOAD, idx, val, $urandom, $urandom, $urandom, RAD_W'($urandom));
    endtask

    task automatic test_sphere(logic signed [VAL_W-1:0] cx, cy, cz, logic [RAD_W-1:0] rad);
        send_beat(FUNC_TEST, IDX_W'($urandom_range(NUM_ENTRY - 1)), $urandom, cx, cy, cz, rad);
    endtask

    // Frustum-like matrix (perspective or ortho) unless wild, then any bits.
    task automatic load_random_matrix(bit wild);
        logic signed [VAL_W-1:0] m [NUM_ENTRY];
        int order [NUM_ENTRY];
        int j;
        int tmp;
        bit persp;
        persp = 1'($urandom_range(1));
        for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
                if (wild)
                    m[col * 4 + row] = $urandom;
                else if (row == 3)
                    m[col * 4 + row] = 0;
                else if (col == row)
                    m[col * 4 + row] = ($urandom_range(9) == 0 ? -1 : 1) *
                                       int'($urandom_range(ONE * 4, ONE / 4));
                else if (col == 3)
                    m[col * 4 + row] = spread(2 * ONE);
                else
                    m[col * 4 + row] = spread(ONE / 8);
            end
        end
        if (!wild) begin
            if (persp) begin
                m[2 * 4 + 3] = -ONE;
                m[3 * 4 + 2] = -int'($urandom_range(4 * ONE, ONE));
            end else begin
                m[3 * 4 + 3] = ONE;
            end
        end
        foreach (order[i]) order[i] = i;
        for (int i = NUM_ENTRY - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i]) load_entry(IDX_W'(order[i]), m[order[i]]);
    endtask

    task automatic test_random_sphere();
        logic [RAD_W-1:0] rad;
        if ($urandom_range(19) == 0) begin
            rad = RAD_W'($urandom);
            test_sphere($urandom, $urandom, $urandom, rad);
        end else begin
            rad = ($urandom_range(15) == 0) ? '0 : RAD_W'($urandom_range(3 * ONE));
            test_sphere(spread(6 * ONE), spread(6 * ONE), spread(12 * ONE), rad);
        end
    endtask

    task automatic wait_drained();
        while (sb.visible_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int episode;
        int n_tests;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty matrix, unit frustum boundaries, then extreme entries
        test_sphere(32'sh8000_0000, 32'sh7FFF_FFFF, '0, 31'h7FFF_FFFF);
        load_entry(0, ONE);
        load_entry(5, ONE);
        load_entry(10, ONE);
        load_entry(15, ONE);
        test_sphere(0, 0, 0, 0);
        test_sphere(ONE, 0, 0, 0);                  // touching plane, zero radius
        test_sphere(2 * ONE, 0, 0, RAD_W'(ONE));    // distance equals -r
        test_sphere(2 * ONE, 0, 0, RAD_W'(ONE + 1));
        test_sphere(0, 0, -3 * ONE, RAD_W'(2 * ONE)); // near plane, equality
        test_sphere(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        test_sphere(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '0);
        load_entry(3, 32'sh8000_0000);
        load_entry(12, 32'sh7FFF_FFFF);
        load_entry(6, 32'sh8000_0000);
        load_entry(9, 32'sh7FFF_FFFF);
        test_sphere(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        test_sphere(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, '0);
        test_sphere(0, 0, 0, RAD_W'(ONE));
        test_sphere(ONE, -ONE, ONE, 31'h7FFF_FFFF);

        episode = 0;
        while (beats_sent < TARGET_BEATS) begin
            quiet = (episode == 4);
            if ($urandom_range(9) == 0)
                load_random_matrix(1'b1);
            else if (episode > 0 && $urandom_range(3) == 0)
                repeat ($urandom_range(4, 1))
                    load_entry(IDX_W'($urandom_range(NUM_ENTRY - 1)), spread(2 * ONE));
            else
                load_random_matrix(1'b0);
            if (episode == 6) hold_request = 1'b1;
            n_tests = (episode == 4) ? 250 : $urandom_range(80, 20);
            repeat (n_tests) begin
                // a load mid-stream must reach the very next test
                if ($urandom_range(32) == 0)
                    load_entry(IDX_W'($urandom_range(NUM_ENTRY - 1)), spread(ONE));
                test_random_sphere();
            end
            if (episode == 8) begin
                @(negedge aclk);
                s_valid = 1'b0;
                wait_drained();
            end
            episode++;
        end
        quiet = 1'b0;
        @(negedge aclk);
        s_valid = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("frustum_sphere_cull_tb: %0d beats over %0d matrices: %0d entry loads, %0d tests",
                 beats_sent, episode, sb.loads, sb.tests);
        $display("frustum_sphere_cull_tb: %0d results checked, %0d culled, %0d mismatches",
                 sb.checked, sb.culled_seen, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("[frustum_sphere_cull] OK");
        end else begin
            $display("[frustum_sphere_cull] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_plane.sv
hw/rtl/frustum_sphere_cull.sv
test/frustum_sphere_cull_tb.sv
